FILE: hdl/cutoff_polynomial_pair_force_core_macros.svh
// assertion macros for the cutoff pair force core
// included by modules that carry concurrent assertions; no other dependencies
`ifndef CUTOFF_POLYNOMIAL_PAIR_FORCE_CORE_MACROS_SVH
`define CUTOFF_POLYNOMIAL_PAIR_FORCE_CORE_MACROS_SVH
`ifndef SYNTH
`define CPF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cpf assertion failed");
`define CPF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cpf assertion failed during or after reset");
`else
`define CPF_ASSERT(lbl, clk, rst_n, prop)
`define CPF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/cpf_pkg.sv
// shared widths, coefficients and types for the cutoff pair force core
// no dependencies
package cpf_pkg;

    localparam int COEF_BITS     = 24;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DISP_W        = 24;
    localparam int FORCE_W       = 32;
    localparam int CUT_W         = 20;
    localparam int SQ_W          = 2 * DISP_W - 1;
    localparam int SUM_W         = SQ_W + 2;
    localparam int RAD_W         = 2 * CUT_W;
    localparam int R_W           = RAD_W / 2;
    localparam int ACC_W         = 44;
    localparam int N_POLY        = 8;
    localparam int N_LANE        = 3;
    localparam int NUM_W         = 63;
    localparam int Q_W           = 32;

    localparam logic [CUT_W-1:0] CUTOFF_RESET = CUT_W'(229376);

    typedef logic signed [ACC_W-1:0] t_acc;

    localparam t_acc ACC_LIM = 44'sd4398046511104;

    // fitted force polynomial, 24 fraction bits, index is the power of r
    localparam t_acc POLY_COEF [N_POLY] = '{
        -44'sd82951312580,
        44'sd188225264026,
        -44'sd181403648000,
        44'sd96047045018,
        -44'sd30111243960,
        44'sd5582350189,
        -44'sd566328348,
        44'sd24251130
    };

    localparam logic signed [FORCE_W-1:0] FORCE_MAX = 32'sh7fffffff;
    localparam logic signed [FORCE_W-1:0] FORCE_MIN = 32'sh80000000;

    typedef struct packed {
        logic                     in_cut;
        logic signed [DISP_W-1:0] dx;
        logic signed [DISP_W-1:0] dy;
        logic signed [DISP_W-1:0] dz;
    } t_geo;

    typedef struct packed {
        t_geo           geo;
        logic [R_W-1:0] r;
    } t_poly_tag;

    typedef struct packed {
        logic in_cut;
        logic poly_sat;
    } t_div_tag;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        logic                      in_cut;
        logic                      sat;
    } t_result;

endpackage

FILE: hdl/cpf_if.sv
// valid/ready channel interfaces: displacement in, force out, cutoff write
// depends on cpf_pkg
interface cpf_disp_if;
    import cpf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DISP_W-1:0] disp_x;
    logic signed [DISP_W-1:0] disp_y;
    logic signed [DISP_W-1:0] disp_z;
    modport source (output valid, disp_x, disp_y, disp_z, input ready);
    modport sink   (input valid, disp_x, disp_y, disp_z, output ready);
endinterface

interface cpf_force_if;
    import cpf_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic                      within_cutoff;
    logic                      force_saturated;
    modport source (output valid, force_x, force_y, force_z, within_cutoff,
                    force_saturated, input ready);
    modport sink   (input valid, force_x, force_y, force_z, within_cutoff,
                    force_saturated, output ready);
endinterface

interface cpf_cfg_if;
    import cpf_pkg::*;
    logic             valid;
    logic             ready;
    logic [CUT_W-1:0] cutoff_distance;
    modport source (output valid, cutoff_distance, input ready);
    modport sink   (input valid, cutoff_distance, output ready);
endinterface

FILE: hdl/cpf_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on cpf_pkg
module cpf_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [cpf_pkg::RAD_W-1:0] i_rad,
    input  cpf_pkg::t_geo             i_tag,
    output logic                      o_valid,
    output logic [cpf_pkg::R_W-1:0]   o_root,
    output cpf_pkg::t_geo             o_tag
);
    import cpf_pkg::*;

    localparam int REM_W = R_W + 2;

    logic             r_v    [R_W];
    logic [REM_W-1:0] r_rem  [R_W];
    logic [R_W-1:0]   r_root [R_W];
    logic [RAD_W-1:0] r_rad  [R_W];
    t_geo             r_tag  [R_W];

    for (genvar k = 0; k < R_W; k++) begin : g_step
        logic             p_v;
        logic [REM_W-1:0] p_rem;
        logic [R_W-1:0]   p_root;
        logic [RAD_W-1:0] p_rad;
        t_geo             p_tag;
        logic [REM_W-1:0] n_t;
        logic [REM_W-1:0] n_trial;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_tag  = i_tag;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_tag  = r_tag[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign n_t     = {p_rem[R_W-1:0], p_rad[RAD_W-1 -: 2]};
        assign n_trial = {p_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
            if (i_en) begin
                r_rad[k] <= {p_rad[RAD_W-3:0], 2'b00};
                r_tag[k] <= p_tag;
                if (n_t >= n_trial) begin
                    r_rem[k]  <= n_t - n_trial;
                    r_root[k] <= {p_root[R_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= n_t;
                    r_root[k] <= {p_root[R_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[R_W-1];
    assign o_root  = r_root[R_W-1];
    assign o_tag   = r_tag[R_W-1];

endmodule

FILE: hdl/cpf_poly.sv
// horner evaluation of the force polynomial, multiply and add/clamp stages
// depends on cpf_pkg
module cpf_poly #(
    parameter int FRACTION_BITS = cpf_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  cpf_pkg::t_poly_tag   i_tag,
    output logic                 o_valid,
    output cpf_pkg::t_acc        o_acc,
    output logic                 o_sat,
    output cpf_pkg::t_poly_tag   o_tag
);
    import cpf_pkg::*;

    localparam int NSTEP  = N_POLY - 1;
    localparam int PROD_W = ACC_W + R_W + 1;
    localparam logic signed [PROD_W-1:0] LIM_HI = PROD_W'(ACC_LIM);
    localparam logic signed [PROD_W-1:0] LIM_LO = -LIM_HI;

    logic                     r_mv   [NSTEP];
    logic signed [PROD_W-1:0] r_prod [NSTEP];
    t_poly_tag                r_mtag [NSTEP];
    logic                     r_msat [NSTEP];
    logic                     r_av   [NSTEP];
    t_acc                     r_acc  [NSTEP];
    t_poly_tag                r_atag [NSTEP];
    logic                     r_asat [NSTEP];

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        logic                     p_v;
        t_acc                     p_acc;
        t_poly_tag                p_tag;
        logic                     p_sat;
        logic signed [PROD_W-1:0] n_prod;
        logic signed [PROD_W-1:0] n_sum;
        t_acc                     n_acc;
        logic                     n_csat;

        if (s == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_acc = POLY_COEF[NSTEP];
            assign p_tag = i_tag;
            assign p_sat = 1'b0;
        end else begin : g_next
            assign p_v   = r_av[s-1];
            assign p_acc = r_acc[s-1];
            assign p_tag = r_atag[s-1];
            assign p_sat = r_asat[s-1];
        end

        assign n_prod = p_acc * $signed({1'b0, p_tag.r});
        // floor shift back to coefficient scale, then add the next coefficient
        assign n_sum  = (r_prod[s] >>> FRACTION_BITS) + PROD_W'(POLY_COEF[NSTEP-1-s]);

        always_comb begin
            priority if (n_sum > LIM_HI) begin
                n_acc  = ACC_LIM;
                n_csat = 1'b1;
            end else if (n_sum < LIM_LO) begin
                n_acc  = -ACC_LIM;
                n_csat = 1'b1;
            end else begin
                n_acc  = n_sum[ACC_W-1:0];
                n_csat = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv[s] <= 1'b0;
                r_av[s] <= 1'b0;
            end else if (i_en) begin
                r_mv[s] <= p_v;
                r_av[s] <= r_mv[s];
            end
            if (i_en) begin
                r_prod[s] <= n_prod;
                r_mtag[s] <= p_tag;
                r_msat[s] <= p_sat;
                r_acc[s]  <= n_acc;
                r_atag[s] <= r_mtag[s];
                r_asat[s] <= r_msat[s] | n_csat;
            end
        end
    end

    assign o_valid = r_av[NSTEP-1];
    assign o_acc   = r_acc[NSTEP-1];
    assign o_sat   = r_asat[NSTEP-1];
    assign o_tag   = r_atag[NSTEP-1];

endmodule

FILE: hdl/cpf_div.sv
// three-lane pipelined restoring divider, overflow check then one quotient bit per stage
// depends on cpf_pkg
module cpf_div #(
    parameter int DEN_W = cpf_pkg::R_W + cpf_pkg::COEF_BITS - cpf_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [cpf_pkg::NUM_W-1:0] i_num [cpf_pkg::N_LANE],
    input  logic                      i_neg [cpf_pkg::N_LANE],
    input  logic [DEN_W-1:0]          i_den,
    input  cpf_pkg::t_div_tag         i_tag,
    output logic                      o_valid,
    output logic [cpf_pkg::Q_W-1:0]   o_q   [cpf_pkg::N_LANE],
    output logic                      o_ovf [cpf_pkg::N_LANE],
    output logic                      o_neg [cpf_pkg::N_LANE],
    output cpf_pkg::t_div_tag         o_tag
);
    import cpf_pkg::*;

    localparam int REM_W = DEN_W + 1;
    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (REM_W > HI_W) ? REM_W : HI_W;
    localparam int NST   = Q_W + 1;

    logic             r_v   [NST];
    logic [DEN_W-1:0] r_den [NST];
    t_div_tag         r_tag [NST];
    logic [REM_W-1:0] r_rem [NST][N_LANE];
    logic [Q_W-1:0]   r_low [NST][N_LANE];
    logic [Q_W-1:0]   r_q   [NST][N_LANE];
    logic             r_ovf [NST][N_LANE];
    logic             r_neg [NST][N_LANE];

    // first stage: quotient too big for the result word
    for (genvar l = 0; l < N_LANE; l++) begin : g_head
        logic [CMP_W-1:0] n_hi;
        assign n_hi = CMP_W'(i_num[l][NUM_W-1:Q_W]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[0][l] <= n_hi >= CMP_W'(i_den);
                r_rem[0][l] <= n_hi[REM_W-1:0];
                r_low[0][l] <= i_num[l][Q_W-1:0];
                r_q[0][l]   <= '0;
                r_neg[0][l] <= i_neg[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 1; k < NST; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (i_en) begin
                r_den[k] <= r_den[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end

        for (genvar l = 0; l < N_LANE; l++) begin : g_lane
            logic [REM_W-1:0] n_t;
            logic             n_ge;
            assign n_t  = {r_rem[k-1][l][DEN_W-1:0], r_low[k-1][l][Q_W-1]};
            assign n_ge = n_t >= {1'b0, r_den[k-1]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k][l] <= n_ge ? n_t - {1'b0, r_den[k-1]} : n_t;
                    r_low[k][l] <= {r_low[k-1][l][Q_W-2:0], 1'b0};
                    r_q[k][l]   <= {r_q[k-1][l][Q_W-2:0], n_ge};
                    r_ovf[k][l] <= r_ovf[k-1][l];
                    r_neg[k][l] <= r_neg[k-1][l];
                end
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_tag   = r_tag[NST-1];
    for (genvar l = 0; l < N_LANE; l++) begin : g_out
        assign o_q[l]   = r_q[NST-1][l];
        assign o_ovf[l] = r_ovf[NST-1][l];
        assign o_neg[l] = r_neg[NST-1][l];
    end

endmodule

FILE: hdl/cutoff_polynomial_pair_force_core.sv
// top level of the cutoff pair force core: squares, cutoff test, sqrt, polynomial,
// force division, saturation and output skid; depends on cpf_pkg, cpf_if,
// cpf_sqrt, cpf_poly, cpf_div and the assertion macro header
//
//  channel   dir  modport  beat payload
//  i_disp    in   sink     disp_x, disp_y, disp_z
//  o_force   out  source   force_x, force_y, force_z, within_cutoff, force_saturated
//  i_cfg     in   sink     cutoff_distance (always ready)
//
// one beat in per cycle while the skid register is empty, one result per beat, in order
// the sqrt and divider bit stages set most of the latency
// reset is synchronous, active low, clears all valid bits and sets the cutoff to 3.5 A
// when o_force stalls, the result parks in a skid register and the pipeline freezes
// the cycle after; i_disp.ready is low only while the skid register is full
`include "cutoff_polynomial_pair_force_core_macros.svh"

module cutoff_polynomial_pair_force_core #(
    parameter int FRACTION_BITS = cpf_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpf_disp_if.sink    i_disp,
    cpf_force_if.source o_force,
    cpf_cfg_if.sink     i_cfg
);
    import cpf_pkg::*;

    localparam int SHIFT = COEF_BITS - FRACTION_BITS;
    localparam int DEN_W = R_W + SHIFT;
    localparam int FP_W  = ACC_W + DISP_W;

    // global advance: the whole pipeline moves unless the skid holds a result
    logic en;

    // cutoff register and its square
    logic [CUT_W-1:0] r_cutoff;
    logic [RAD_W-1:0] r_cut_sq;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RESET;
        end else if (i_cfg.valid) begin
            r_cutoff <= i_cfg.cutoff_distance;
        end
        r_cut_sq <= r_cutoff * r_cutoff;
    end

    // stage 1: input capture
    logic                     r_s1_v;
    logic signed [DISP_W-1:0] r_s1_d [N_LANE];

    assign i_disp.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_disp.valid;
        end
        if (en) begin
            r_s1_d[0] <= i_disp.disp_x;
            r_s1_d[1] <= i_disp.disp_y;
            r_s1_d[2] <= i_disp.disp_z;
        end
    end

    // stage 2: squares, exact
    logic                       r_s2_v;
    logic signed [DISP_W-1:0]   r_s2_d  [N_LANE];
    logic [SQ_W-1:0]            r_s2_sq [N_LANE];
    logic signed [2*DISP_W-1:0] n_sq    [N_LANE];

    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            n_sq[l] = r_s1_d[l] * r_s1_d[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
        if (en) begin
            for (int l = 0; l < N_LANE; l++) begin
                r_s2_d[l]  <= r_s1_d[l];
                r_s2_sq[l] <= n_sq[l][SQ_W-1:0];
            end
        end
    end

    // stage 3: sum of squares and cutoff test
    // inside the cutoff the sum is below 2^40, so the radicand fits 40 bits
    logic             r_s3_v;
    logic [RAD_W-1:0] r_s3_rad;
    t_geo             r_s3_geo;
    logic [SUM_W-1:0] n_sum;
    logic             n_in_cut;

    assign n_sum    = SUM_W'(r_s2_sq[0]) + SUM_W'(r_s2_sq[1]) + SUM_W'(r_s2_sq[2]);
    assign n_in_cut = (n_sum != '0) && (n_sum < SUM_W'(r_cut_sq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
        if (en) begin
            r_s3_rad        <= n_sum[RAD_W-1:0];
            r_s3_geo.in_cut <= n_in_cut;
            r_s3_geo.dx     <= r_s2_d[0];
            r_s3_geo.dy     <= r_s2_d[1];
            r_s3_geo.dz     <= r_s2_d[2];
        end
    end

    // distance r = floor(sqrt(sum)), FRACTION_BITS fraction bits
    logic           sq_v;
    logic [R_W-1:0] sq_root;
    t_geo           sq_geo;
    t_poly_tag      sq_tag;

    cpf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_v),
        .i_rad   (r_s3_rad),
        .i_tag   (r_s3_geo),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_tag   (sq_geo)
    );

    assign sq_tag.geo = sq_geo;
    assign sq_tag.r   = sq_root;

    // polynomial P(r), 24 fraction bits, clamped each step
    logic      po_v;
    t_acc      po_acc;
    logic      po_sat;
    t_poly_tag po_tag;

    cpf_poly #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_tag   (sq_tag),
        .o_valid (po_v),
        .o_acc   (po_acc),
        .o_sat   (po_sat),
        .o_tag   (po_tag)
    );

    // force stage 1: P * d per lane, denominator r scaled to coefficient fraction bits
    logic signed [DISP_W-1:0] po_d [N_LANE];
    logic                     r_f1_v;
    logic signed [FP_W-1:0]   r_f1_prod [N_LANE];
    logic [DEN_W-1:0]         r_f1_den;
    t_div_tag                 r_f1_tag;

    assign po_d[0] = po_tag.geo.dx;
    assign po_d[1] = po_tag.geo.dy;
    assign po_d[2] = po_tag.geo.dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= po_v;
        end
        if (en) begin
            for (int l = 0; l < N_LANE; l++) begin
                r_f1_prod[l] <= po_acc * po_d[l];
            end
            r_f1_den          <= DEN_W'(po_tag.r) << SHIFT;
            r_f1_tag.in_cut   <= po_tag.geo.in_cut;
            r_f1_tag.poly_sat <= po_sat;
        end
    end

    // force stage 2: sign of -P*d, magnitude plus half the denominator for rounding
    // inside the cutoff |d| < 2^20 and |P| <= 2^42, so the magnitude stays below 2^62
    logic signed [FP_W-1:0] n_mag [N_LANE];
    logic [NUM_W-1:0]       n_num [N_LANE];
    logic                   n_neg [N_LANE];
    logic                   r_f2_v;
    logic [NUM_W-1:0]       r_f2_num [N_LANE];
    logic                   r_f2_neg [N_LANE];
    logic [DEN_W-1:0]       r_f2_den;
    t_div_tag               r_f2_tag;

    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            n_mag[l] = r_f1_prod[l][FP_W-1] ? -r_f1_prod[l] : r_f1_prod[l];
            n_num[l] = NUM_W'($unsigned(n_mag[l])) + NUM_W'(r_f1_den >> 1);
            n_neg[l] = !r_f1_prod[l][FP_W-1] && (r_f1_prod[l] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (en) begin
            r_f2_v <= r_f1_v;
        end
        if (en) begin
            r_f2_num <= n_num;
            r_f2_neg <= n_neg;
            r_f2_den <= r_f1_den;
            r_f2_tag <= r_f1_tag;
        end
    end

    // rounded quotient per lane
    logic           dv_v;
    logic [Q_W-1:0] dv_q   [N_LANE];
    logic           dv_ovf [N_LANE];
    logic           dv_neg [N_LANE];
    t_div_tag       dv_tag;

    cpf_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f2_v),
        .i_num   (r_f2_num),
        .i_neg   (r_f2_neg),
        .i_den   (r_f2_den),
        .i_tag   (r_f2_tag),
        .o_valid (dv_v),
        .o_q     (dv_q),
        .o_ovf   (dv_ovf),
        .o_neg   (dv_neg),
        .o_tag   (dv_tag)
    );

    // saturation to 32 bits; outside the cutoff everything reads zero
    logic signed [FORCE_W-1:0] n_force [N_LANE];
    logic                      n_lsat  [N_LANE];
    t_result                   n_res;

    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            priority if (dv_ovf[l]) begin
                n_force[l] = dv_neg[l] ? FORCE_MIN : FORCE_MAX;
                n_lsat[l]  = 1'b1;
            end else if (dv_neg[l]) begin
                if (dv_q[l][Q_W-1] && (dv_q[l][Q_W-2:0] != '0)) begin
                    n_force[l] = FORCE_MIN;
                    n_lsat[l]  = 1'b1;
                end else begin
                    n_force[l] = -$signed(dv_q[l]);
                    n_lsat[l]  = 1'b0;
                end
            end else if (dv_q[l][Q_W-1]) begin
                n_force[l] = FORCE_MAX;
                n_lsat[l]  = 1'b1;
            end else begin
                n_force[l] = $signed(dv_q[l]);
                n_lsat[l]  = 1'b0;
            end
            if (!dv_tag.in_cut) begin
                n_force[l] = '0;
                n_lsat[l]  = 1'b0;
            end
        end
        n_res.force_x = n_force[0];
        n_res.force_y = n_force[1];
        n_res.force_z = n_force[2];
        n_res.in_cut  = dv_tag.in_cut;
        n_res.sat     = dv_tag.in_cut &
                        (dv_tag.poly_sat | n_lsat[0] | n_lsat[1] | n_lsat[2]);
    end

    // output register plus skid register
    logic    r_o_v;
    t_result r_o;
    logic    r_sk_v;
    t_result r_sk;
    logic    n_move;
    logic    res_zero;

    assign en     = !r_sk_v;
    assign n_move = en && dv_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (o_force.ready || !r_o_v) begin
            if (r_sk_v) begin
                r_o_v  <= 1'b1;
                r_sk_v <= 1'b0;
            end else begin
                r_o_v <= n_move;
            end
        end else if (n_move) begin
            r_sk_v <= 1'b1;
        end
        if (o_force.ready || !r_o_v) begin
            r_o <= r_sk_v ? r_sk : n_res;
        end else if (n_move) begin
            r_sk <= n_res;
        end
    end

    assign o_force.valid           = r_o_v;
    assign o_force.force_x         = r_o.force_x;
    assign o_force.force_y         = r_o.force_y;
    assign o_force.force_z         = r_o.force_z;
    assign o_force.within_cutoff   = r_o.in_cut;
    assign o_force.force_saturated = r_o.sat;

    assign res_zero = ({r_o.force_x, r_o.force_y, r_o.force_z} == '0) && !r_o.sat;

    // a parked beat always has one ahead of it in the output register
    `CPF_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_sk_v |-> r_o_v)
    // a taken output frees the skid in the next cycle
    `CPF_ASSERT(a_skid_drains, i_clk, i_rst_n, r_sk_v && o_force.ready |=> !r_sk_v)
    // outside the cutoff the result is all zero
    `CPF_ASSERT(a_outside_zero, i_clk, i_rst_n, r_o_v && !r_o.in_cut |-> res_zero)
    // a pair inside the cutoff never yields a zero distance
    `CPF_ASSERT(a_root_nonzero, i_clk, i_rst_n, sq_v && sq_geo.in_cut |-> sq_root != '0)
    // reset empties the output side
    `CPF_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !r_o_v && !r_sk_v)

endmodule

FILE: sim/tb_cutoff_polynomial_pair_force_core.sv
// self-checking bench for the cutoff pair force core: directed table, then random phases
// at several cutoff settings, every force beat checked against a bit-true predictor
// depends on cpf_pkg, cpf_if and cutoff_polynomial_pair_force_core
module tb_cutoff_polynomial_pair_force_core;
    import cpf_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int PIPE_LATENCY  = 73;
    localparam int STALL_LIMIT   = 6000;
    localparam int PHASE_ITEMS   = 180;
    localparam int HOLD_CYCLES   = 300;
    localparam int N_PHASE       = 9;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #HALF_PERIOD i_clk = ~i_clk;

    cpf_disp_if  disp_ch ();
    cpf_force_if force_ch ();
    cpf_cfg_if   cfg_ch ();

    cutoff_polynomial_pair_force_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_disp  (disp_ch),
        .o_force (force_ch),
        .i_cfg   (cfg_ch)
    );

    // expected force beats, oldest first
    t_result          force_expect_q[$];
    logic [CUT_W-1:0] model_cutoff;
    int               err_count;
    int               idle_cycles;
    bit               quiet;
    bit               hold_req;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // bitwise integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // -p*d/den, rounded half away from zero, clipped to 32 bits
    function automatic logic signed [FORCE_W-1:0] scale_force(longint p, longint d,
            longint unsigned den, inout bit sat);
        longint          num;
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        num = -(p * d);
        neg = num < 0;
        mag = neg ? longint'(-num) : num;
        q   = (mag + den / 2) / den;
        if (neg) begin
            if (q > (64'd1 << 31)) begin
                q   = 64'd1 << 31;
                sat = 1'b1;
            end
            return FORCE_W'(-q);
        end
        if (q > 64'h7fffffff) begin
            q   = 64'h7fffffff;
            sat = 1'b1;
        end
        return FORCE_W'(q);
    endfunction

    function automatic t_result predict_force(int dx, int dy, int dz, logic [CUT_W-1:0] cut);
        t_result         res;
        longint unsigned sum;
        longint unsigned cut_sq;
        longint          r;
        longint          acc;
        longint          lim;
        longint unsigned den;
        bit              sat;
        res    = '0;
        sum    = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz;
        cut_sq = longint'(cut) * cut;
        if (sum == 0 || sum >= cut_sq) return res;
        r   = int_sqrt(sum);
        lim = longint'(ACC_LIM);
        sat = 1'b0;
        // horner on r, accumulator clamped after every step
        acc = longint'(POLY_COEF[7]);
        for (int k = 6; k >= 0; k--) begin
            acc = ((acc * r) >>> FRAC_BITS_DEF) + longint'(POLY_COEF[k]);
            if (acc > lim) begin
                acc = lim;
                sat = 1'b1;
            end else if (acc < -lim) begin
                acc = -lim;
                sat = 1'b1;
            end
        end
        den          = longint'(r) << (COEF_BITS - FRAC_BITS_DEF);
        res.force_x  = scale_force(acc, dx, den, sat);
        res.force_y  = scale_force(acc, dy, den, sat);
        res.force_z  = scale_force(acc, dz, den, sat);
        res.in_cut   = 1'b1;
        res.sat      = sat;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic check_field(string what, longint got, longint want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // force beat monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && force_ch.valid && force_ch.ready) begin
            if (force_expect_q.size() == 0) begin
                report_mismatch("unexpected force beat", force_ch.force_x, 0);
            end else begin
                want = force_expect_q.pop_front();
                check_field("force_x", force_ch.force_x, want.force_x);
                check_field("force_y", force_ch.force_y, want.force_y);
                check_field("force_z", force_ch.force_z, want.force_z);
                check_field("within_cutoff", force_ch.within_cutoff, want.in_cut);
                check_field("force_saturated", force_ch.force_saturated, want.sat);
            end
        end
    end

    // watchdog: cycles in a row with no beat on any channel
    always @(posedge i_clk) begin
        if ((disp_ch.valid && disp_ch.ready) || (force_ch.valid && force_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // receiver: random ready bursts, one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        force_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                // long back-pressure so the pipe fills and i_disp stalls
                force_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                force_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                force_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // one displacement beat, expectation queued on acceptance
    task automatic send_disp(int dx, int dy, int dz, bit typed_zero);
        t_result want;
        disp_ch.valid  <= 1'b1;
        disp_ch.disp_x <= DISP_W'(dx);
        disp_ch.disp_y <= DISP_W'(dy);
        disp_ch.disp_z <= DISP_W'(dz);
        do @(posedge i_clk); while (!disp_ch.ready);
        want = typed_zero ? t_result'('0) : predict_force(dx, dy, dz, model_cutoff);
        force_expect_q.push_back(want);
        // random gap on the sender side
        if (!quiet && $urandom_range(0, 3) == 0) begin
            disp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // cutoff write, only with the pipe drained
    task automatic write_cutoff(logic [CUT_W-1:0] cut);
        disp_ch.valid <= 1'b0;
        wait (force_expect_q.size() == 0);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.cutoff_distance <= cut;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        model_cutoff = cut;
    endtask

    // random displacement: mostly components within the cutoff, rest full-range noise
    task automatic random_disp(output int dx, output int dy, output int dz);
        int lim;
        lim = int'(model_cutoff);
        if ($urandom_range(0, 3) == 0 || lim == 0) begin
            dx = int'($signed(DISP_W'($urandom())));
            dy = int'($signed(DISP_W'($urandom())));
            dz = int'($signed(DISP_W'($urandom())));
        end else begin
            if ($urandom_range(0, 3) == 0) lim = (lim >> 3) + 1;
            dx = int'($urandom_range(0, 2 * lim)) - lim;
            dy = int'($urandom_range(0, 2 * lim)) - lim;
            dz = int'($urandom_range(0, 2 * lim)) - lim;
        end
    endtask

    typedef struct {
        logic [CUT_W-1:0] cut;
        int               dx;
        int               dy;
        int               dz;
        bit               typed_zero;
    } t_stim_row;

    // directed rows; typed_zero rows carry the all-zero result
    localparam int N_ROWS = 19;
    t_stim_row stim_rows [N_ROWS] = '{
        '{CUTOFF_RESET, 0, 0, 0, 1'b1},                        // zero distance
        '{CUTOFF_RESET, 229376, 0, 0, 1'b1},                   // exactly at cutoff
        '{CUTOFF_RESET, 229375, 0, 0, 1'b0},                   // just inside
        '{CUTOFF_RESET, 0, 0, 1, 1'b0},                        // smallest r
        '{CUTOFF_RESET, -1, -1, -1, 1'b0},
        '{CUTOFF_RESET, -8388608, -8388608, -8388608, 1'b1},   // most negative
        '{CUTOFF_RESET, 8388607, 8388607, 8388607, 1'b1},      // most positive
        '{CUTOFF_RESET, 0, -229375, 0, 1'b0},
        '{CUTOFF_RESET, 65536, 65536, 65536, 1'b0},
        '{20'hfffff, 1048574, 0, 0, 1'b0},                     // polynomial clamp
        '{20'hfffff, 0, 700000, -700000, 1'b0},                // component clip
        '{20'hfffff, -1048575, 0, 0, 1'b1},
        '{20'hfffff, 500000, -300000, 200000, 1'b0},
        '{20'h00000, 1, 0, 0, 1'b1},                           // zero cutoff
        '{20'h00000, 0, 0, 0, 1'b1},
        '{20'h00001, 1, 0, 0, 1'b1},                           // sum equals cutoff squared
        '{20'h00001, 0, 0, 0, 1'b1},
        '{20'h00002, 1, 1, 1, 1'b0},
        '{20'h00002, -1, 0, 0, 1'b0}
    };

    logic [CUT_W-1:0] phase_cut [N_PHASE];

    initial begin
        int dx;
        int dy;
        int dz;
        err_count      = 0;
        quiet          = 1'b0;
        hold_req       = 1'b0;
        model_cutoff   = CUTOFF_RESET;
        i_rst_n        <= 1'b0;
        disp_ch.valid  <= 1'b0;
        disp_ch.disp_x <= '0;
        disp_ch.disp_y <= '0;
        disp_ch.disp_z <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.cutoff_distance <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, cutoff rewritten only when a row asks for another one
        foreach (stim_rows[i]) begin
            if (stim_rows[i].cut != model_cutoff) write_cutoff(stim_rows[i].cut);
            send_disp(stim_rows[i].dx, stim_rows[i].dy, stim_rows[i].dz,
                      stim_rows[i].typed_zero);
        end

        // random phases over several cutoffs, extremes included
        phase_cut[0] = CUTOFF_RESET;
        phase_cut[1] = 20'hfffff;
        phase_cut[2] = 20'h00000;
        phase_cut[3] = 20'h00001;
        phase_cut[4] = 20'h10000;
        for (int p = 5; p < N_PHASE; p++) phase_cut[p] = CUT_W'($urandom());
        for (int p = 0; p < N_PHASE; p++) begin
            write_cutoff(phase_cut[p]);
            // the final phase runs with no idling on either side
            quiet = (p == N_PHASE - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 0 && n == 40) hold_req = 1'b1;
                random_disp(dx, dy, dz);
                send_disp(dx, dy, dz, 1'b0);
            end
        end
        disp_ch.valid <= 1'b0;

        // drain, then let the pipe settle
        wait (force_expect_q.size() == 0);
        repeat (PIPE_LATENCY + 20) @(posedge i_clk);
        if (err_count == 0 && force_expect_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/cpf_pkg.sv
hdl/cpf_if.sv
hdl/cpf_sqrt.sv
hdl/cpf_poly.sv
hdl/cpf_div.sv
hdl/cutoff_polynomial_pair_force_core.sv
sim/tb_cutoff_polynomial_pair_force_core.sv
